[sv/att_pkg.sv]
// Shared types and codes for the acknowledgement timeout tracker.
`default_nettype none

package att_pkg;

    // Input item function codes.
    localparam logic [1:0] FUNC_REGISTER = 2'd0;
    localparam logic [1:0] FUNC_PACKET   = 2'd1;
    localparam logic [1:0] FUNC_TICK     = 2'd2;

    // Result event codes.
    localparam logic [2:0] EV_REGISTERED = 3'd0;
    localparam logic [2:0] EV_FULL       = 3'd1;
    localparam logic [2:0] EV_ACKED      = 3'd2;
    localparam logic [2:0] EV_NACKED     = 3'd3;
    localparam logic [2:0] EV_TIMEOUT    = 3'd4;

    // Configuration register indexes.
    localparam logic REG_ENABLE = 1'b0;

    // Most results a single item may produce.
    localparam int MAX_OUT = 8;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    localparam int SEQ_W   = 8;
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 16;

    // One tracker entry as held in the slot memory.
    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [TIME_W-1:0]  start;
        logic [LIMIT_W-1:0] limit;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

`default_nettype wire

[sv/att_slot_ram.sv]
// Slot memory: one write port and one registered read port.
`default_nettype none

module att_slot_ram
    import att_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire slot_entry_t       wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output slot_entry_t            rd_data
);

    slot_entry_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/ack_timeout_tracker.sv]
// Top level of the acknowledgement timeout tracker.
`default_nettype none

// A transaction is taken when start is high and busy is low. A register
// item walks the busy flags one slot per cycle and claims the first free
// slot. A packet or tick item streams every slot through the slot memory's
// registered read port, one slot per cycle, and checks it with a single
// shared compare unit (sequence match or elapsed-time subtract and compare),
// visiting every slot however many events it finds. Each result is
// presented for exactly one cycle with done high; last marks the final
// result of the transaction, and the receiver cannot hold results off.
// No clearing pass is needed after reset.
module ack_timeout_tracker
    import att_pkg::*;
#(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  seq,
    input  wire logic [15:0] wait_limit,
    input  wire logic        is_ack,
    input  wire logic        ack_ok,
    // Result channel
    output logic             done,
    output logic [2:0]       event_res,
    output logic [2:0]       slot,
    output logic [7:0]       seq_out,
    output logic             last,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t                 state_reg;
    logic                   enable_reg;
    logic [TIME_W-1:0]      time_now_reg;
    logic [NUM_SLOTS-1:0]   slot_busy_reg;

    // Latched command.
    logic [1:0]             func_reg;
    logic [SEQ_W-1:0]       seq_reg;
    logic [LIMIT_W-1:0]     limit_reg;
    logic [2:0]             pkt_ev_reg;

    // Scan pipeline: issue stage and check stage.
    logic [IDX_W-1:0]       idx_reg;
    logic                   issue_reg;
    logic [IDX_W-1:0]       chk_idx_reg;
    logic                   chk_valid_reg;
    logic [CNT_W-1:0]       found_cnt_reg;

    // Event held back until we know whether it is the last one.
    logic                   pend_valid_reg;
    logic [2:0]             pend_ev_reg;
    logic [2:0]             pend_slot_reg;
    logic [SEQ_W-1:0]       pend_seq_reg;

    // Result output registers.
    logic                   done_reg;
    logic [2:0]             event_res_reg;
    logic [2:0]             slot_reg;
    logic [SEQ_W-1:0]       seq_out_reg;
    logic                   last_reg;

    logic                   accept;
    logic                   cfg_write;
    logic                   scan_func;
    logic                   ram_wr_en;
    slot_entry_t            ram_wr_data;
    logic                   ram_rd_en;
    slot_entry_t            ram_rd_data;
    logic [TIME_W-1:0]      elapsed;
    logic                   hit;
    logic                   qualify;

    assign accept    = start && (state_reg == ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign scan_func = (func_reg != FUNC_REGISTER);

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENABLE) ? {31'd0, enable_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (cfg_write && (paddr[2] == REG_ENABLE))
        begin
            enable_reg <= pwdata[0];
        end
    end

    // Slot memory: written by a register item, read by the scan.
    assign ram_wr_en = (state_reg == ST_SCAN) && !scan_func && !slot_busy_reg[idx_reg];
    assign ram_wr_data = '{seq: seq_reg, start: time_now_reg, limit: limit_reg};
    assign ram_rd_en = (state_reg == ST_SCAN) && scan_func && issue_reg;

    att_slot_ram #(
        .DEPTH (NUM_SLOTS),
        .AW    (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // Shared check unit: sequence match for packets, elapsed-time compare for ticks.
    assign elapsed = time_now_reg - ram_rd_data.start;

    always_comb
    begin
        unique case (func_reg)
            FUNC_PACKET: hit = (ram_rd_data.seq == seq_reg);
            FUNC_TICK:   hit = (elapsed >= {{(TIME_W - LIMIT_W){1'b0}}, ram_rd_data.limit});
            default:     hit = 1'b0;
        endcase
    end

    assign qualify = (state_reg == ST_SCAN) && chk_valid_reg && enable_reg
                     && slot_busy_reg[chk_idx_reg] && hit
                     && (found_cnt_reg < CNT_W'(MAX_OUT));

    // Sequencer with its registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            time_now_reg   <= '0;
            slot_busy_reg  <= '0;
            func_reg       <= FUNC_REGISTER;
            seq_reg        <= '0;
            limit_reg      <= '0;
            pkt_ev_reg     <= EV_ACKED;
            idx_reg        <= '0;
            issue_reg      <= 1'b0;
            chk_idx_reg    <= '0;
            chk_valid_reg  <= 1'b0;
            found_cnt_reg  <= '0;
            pend_valid_reg <= 1'b0;
            pend_ev_reg    <= EV_ACKED;
            pend_slot_reg  <= '0;
            pend_seq_reg   <= '0;
            done_reg       <= 1'b0;
            event_res_reg  <= EV_REGISTERED;
            slot_reg       <= '0;
            seq_out_reg    <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg       <= func;
                        seq_reg        <= seq;
                        limit_reg      <= wait_limit;
                        pkt_ev_reg     <= (is_ack && !ack_ok) ? EV_NACKED : EV_ACKED;
                        idx_reg        <= '0;
                        issue_reg      <= 1'b1;
                        chk_valid_reg  <= 1'b0;
                        found_cnt_reg  <= '0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                        if (func == FUNC_TICK)
                        begin
                            time_now_reg <= time_now_reg + TIME_W'(1);
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (!scan_func)
                    begin
                        // Register item: claim the lowest free slot.
                        if (!slot_busy_reg[idx_reg])
                        begin
                            slot_busy_reg[idx_reg] <= 1'b1;
                            done_reg      <= 1'b1;
                            event_res_reg <= EV_REGISTERED;
                            slot_reg      <= 3'(idx_reg);
                            seq_out_reg   <= seq_reg;
                            last_reg      <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                        else if (idx_reg == LAST_IDX)
                        begin
                            done_reg      <= 1'b1;
                            event_res_reg <= EV_FULL;
                            slot_reg      <= '0;
                            seq_out_reg   <= seq_reg;
                            last_reg      <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        // Issue stage: read the next slot.
                        chk_valid_reg <= issue_reg;
                        chk_idx_reg   <= idx_reg;
                        if (issue_reg)
                        begin
                            if (idx_reg == LAST_IDX)
                            begin
                                issue_reg <= 1'b0;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + IDX_W'(1);
                            end
                        end

                        // Check stage: release the held event when a new one is found.
                        if (qualify)
                        begin
                            slot_busy_reg[chk_idx_reg] <= 1'b0;
                            found_cnt_reg  <= found_cnt_reg + CNT_W'(1);
                            pend_valid_reg <= 1'b1;
                            pend_ev_reg    <= (func_reg == FUNC_TICK) ? EV_TIMEOUT : pkt_ev_reg;
                            pend_slot_reg  <= 3'(chk_idx_reg);
                            pend_seq_reg   <= ram_rd_data.seq;
                            if (pend_valid_reg)
                            begin
                                done_reg      <= 1'b1;
                                event_res_reg <= pend_ev_reg;
                                slot_reg      <= pend_slot_reg;
                                seq_out_reg   <= pend_seq_reg;
                                last_reg      <= 1'b0;
                            end
                        end

                        if (chk_valid_reg && (chk_idx_reg == LAST_IDX))
                        begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end

                ST_FLUSH:
                begin
                    // The held event, if any, is the final one.
                    if (pend_valid_reg)
                    begin
                        done_reg      <= 1'b1;
                        event_res_reg <= pend_ev_reg;
                        slot_reg      <= pend_slot_reg;
                        seq_out_reg   <= pend_seq_reg;
                        last_reg      <= 1'b1;
                    end
                    pend_valid_reg <= 1'b0;
                    chk_valid_reg  <= 1'b0;
                    state_reg      <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign event_res = event_res_reg;
    assign slot      = slot_reg;
    assign seq_out   = seq_out_reg;
    assign last      = last_reg;

    // The final result of a transaction is never followed directly by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && last |=> !done)
        else $error("result strobe right after a final result");

    // A result that is not the final one arrives while the transaction is still open.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |-> busy)
        else $error("non-final result after the transaction closed");

    // An accepted transaction holds off the next one from the following cycle, with no result in that cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted transaction did not start a scan");

    // Event codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (event_res == EV_REGISTERED) || (event_res == EV_FULL)
              || (event_res == EV_ACKED) || (event_res == EV_NACKED)
              || (event_res == EV_TIMEOUT))
        else $error("undefined event code on the result port");

endmodule

`default_nettype wire
